// ===== hw/rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg
// shared constants and types for the de casteljau bezier evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  // operation codes carried on the opcode field
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_EVAL   = 2'd2
  } opcode_e;

  // field widths fixed by the interface
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned IN_COORD_W = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned INDEX_W    = 4;

  // curve parameter, unsigned q0.16 with one extra bit so 1.0 fits
  localparam int unsigned T_W         = 17;
  localparam int unsigned T_FRAC_BITS = 16;
  localparam logic [T_W-1:0] T_ONE    = 17'h1_0000;

  // half an lsb of the shifted result, for round to nearest with ties upward
  localparam int ROUND_HALF = 32768;

endpackage : bdc_pkg

`default_nettype wire

// ===== hw/rtl/bdc_lerp.sv =====
// ----------------------------------------------------------------------------
// bdc_lerp
// one coordinate lane of the blend a + round(t * (b - a)), one register stage
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_lerp
  import bdc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire logic signed [COORD_BITS-1:0] a_i,
  input  wire logic signed [COORD_BITS-1:0] b_i,
  input  wire logic [T_W-1:0]          t_i,
  output logic signed [COORD_BITS-1:0] res_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + T_W + 1;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [T_W:0]          t_s;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [COORD_BITS-1:0] a_q;
  logic signed [PROD_W-1:0]     rounded;
  logic signed [PROD_W-1:0]     res_full;

  assign diff = DIFF_W'(b_i) - DIFF_W'(a_i);
  assign t_s  = {1'b0, t_i};
  assign prod = PROD_W'(diff) * PROD_W'(t_s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod;
      a_q    <= a_i;
    end
  end

  // floor of (prod + half) / 2^16; for t up to 1.0 the result lies between a and b
  assign rounded  = (prod_q + PROD_W'(ROUND_HALF)) >>> T_FRAC_BITS;
  assign res_full = PROD_W'(a_q) + rounded;
  assign res_o    = res_full[COORD_BITS-1:0];

endmodule : bdc_lerp

`default_nettype wire

// ===== hw/rtl/bezier_de_casteljau_eval.sv =====
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval
// de casteljau evaluation of a 3-d bezier curve held in on-chip memory
// ----------------------------------------------------------------------------
// usage
//   a word is taken on a rising edge with start_i high and busy_o low
//   opcode append stores one control point (dropped when the store is full),
//   clear empties the store; both finish in the accepting cycle, no results
//   opcode evaluate with n stored points and L levels (clamped to n-1) runs
//   L reduction passes over the scratch memory, then emits n-L points, one
//   per cycle, each marked by point_valid_o for exactly one cycle, with
//   last_point_o high on the final one; an empty store gives nothing
// passes and emission
//   pass k reads n-k entries through the single read port, one per cycle,
//   then waits for the blend pipeline to drain before the next pass; an
//   emitted point goes through the memory read register and the result
//   register before it leaves, then the points follow one per cycle
// reset
//   the point count clears; memory contents are not touched
// the receiver has no back pressure: results must be taken as they come
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_de_casteljau_eval
  import bdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // command side
  input  wire                    start_i,
  output logic                   busy_o,
  input  wire  [OPCODE_W-1:0]    opcode_i,
  input  wire  [IN_COORD_W-1:0]  coord_x_i,
  input  wire  [IN_COORD_W-1:0]  coord_y_i,
  input  wire  [IN_COORD_W-1:0]  coord_z_i,
  input  wire  [T_W-1:0]         t_value_i,
  input  wire  [LEVEL_W-1:0]     levels_i,
  // result side
  output logic                   point_valid_o,
  output logic [OUT_W-1:0]       point_x_o,
  output logic [OUT_W-1:0]       point_y_o,
  output logic [OUT_W-1:0]       point_z_o,
  output logic [INDEX_W-1:0]     point_index_o,
  output logic                   last_point_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_DRAIN,
    S_EMIT
  } state_e;

  // one memory word holds x, y and z of a point
  typedef logic [2:0][COORD_BITS-1:0] word_t;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;     // stored points
  logic [CNT_W-1:0]   len_q;       // points alive in the current level
  logic [LEVEL_W-1:0] lv_q;        // reduction passes still to run
  logic [T_W-1:0]     t_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               from_scr_q;  // later passes, and emission after a pass, read scratch

  // read stage, aligned with the registered memory outputs
  logic               d1_valid_q;
  logic               d1_emit_q;
  logic               d1_last_q;
  logic               d1_scr_q;
  logic [IDX_W-1:0]   d1_idx_q;

  // blend stage, aligned with the lerp product registers
  logic               s1_valid_q;
  logic [IDX_W-1:0]   s1_addr_q;

  // result register
  logic               out_valid_q;
  logic               out_last_q;
  logic [IDX_W-1:0]   out_idx_q;
  word_t              out_word_q;

  word_t point_mem [MAX_POINTS];
  word_t scratch_mem [MAX_POINTS];
  word_t pt_rd_q;
  word_t sc_rd_q;
  word_t rd_word;
  word_t prev_q;
  word_t blend_res;
  word_t in_word;

  logic             accept;
  logic             do_append;
  logic             rd_en;
  logic             rd_at_end;
  logic             lerp_en;
  logic [CMP_W-1:0] lvl_ext;
  logic [CMP_W-1:0] cnt_m1;
  logic [CMP_W-1:0] lv_sel;
  logic [T_W-1:0]   t_sat;

  assign accept    = start_i && (state_q == S_IDLE);
  assign do_append = accept && (opcode_e'(opcode_i) == OP_APPEND)
                     && (count_q < CNT_W'(MAX_POINTS));

  // incoming coordinates keep their low COORD_BITS bits
  assign in_word[0] = coord_x_i[COORD_BITS-1:0];
  assign in_word[1] = coord_y_i[COORD_BITS-1:0];
  assign in_word[2] = coord_z_i[COORD_BITS-1:0];

  // level clamp and parameter saturation at the start of an evaluation
  assign lvl_ext = CMP_W'(levels_i);
  assign cnt_m1  = CMP_W'(count_q) - CMP_W'(1);
  assign lv_sel  = (lvl_ext > cnt_m1) ? cnt_m1 : lvl_ext;
  assign t_sat   = (t_value_i > T_ONE) ? T_ONE : t_value_i;

  assign rd_en     = (state_q == S_PASS) || (state_q == S_EMIT);
  assign rd_at_end = (CNT_W'(rd_idx_q) == (len_q - CNT_W'(1)));

  // sequencer: state, counters, pipeline control and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      lv_q        <= '0;
      t_q         <= '0;
      rd_idx_q    <= '0;
      from_scr_q  <= 1'b0;
      d1_valid_q  <= 1'b0;
      d1_emit_q   <= 1'b0;
      d1_last_q   <= 1'b0;
      d1_scr_q    <= 1'b0;
      d1_idx_q    <= '0;
      s1_valid_q  <= 1'b0;
      s1_addr_q   <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      d1_valid_q  <= rd_en;
      d1_emit_q   <= (state_q == S_EMIT);
      d1_last_q   <= rd_at_end;
      d1_scr_q    <= from_scr_q;
      d1_idx_q    <= rd_idx_q;
      s1_valid_q  <= lerp_en;
      s1_addr_q   <= d1_idx_q - IDX_W'(1);
      out_valid_q <= d1_valid_q && d1_emit_q;
      out_last_q  <= d1_last_q;
      out_idx_q   <= d1_idx_q;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (opcode_e'(opcode_i))
              OP_APPEND: begin
                if (do_append) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_CLEAR: begin
                count_q <= '0;
              end
              OP_EVAL: begin
                if (count_q != '0) begin
                  len_q      <= count_q;
                  lv_q       <= LEVEL_W'(lv_sel);
                  t_q        <= t_sat;
                  rd_idx_q   <= '0;
                  from_scr_q <= 1'b0;
                  state_q    <= (lv_sel == '0) ? S_EMIT : S_PASS;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PASS: begin
          if (rd_at_end) begin
            rd_idx_q <= '0;
            state_q  <= S_DRAIN;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // wait until the last blend of the pass is in scratch
          if (!d1_valid_q && !s1_valid_q) begin
            len_q      <= len_q - CNT_W'(1);
            lv_q       <= lv_q - LEVEL_W'(1);
            from_scr_q <= 1'b1;
            state_q    <= (lv_q == LEVEL_W'(1)) ? S_EMIT : S_PASS;
          end
        end
        S_EMIT: begin
          if (rd_at_end) begin
            rd_idx_q <= '0;
            state_q  <= S_IDLE;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // control point memory: append writes, passes and emission read
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      point_mem[count_q[IDX_W-1:0]] <= in_word;
    end
    if (rd_en) begin
      pt_rd_q <= point_mem[rd_idx_q];
    end
  end

  // scratch memory: blend results written back, read by later passes and emission
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      scratch_mem[s1_addr_q] <= blend_res;
    end
    if (rd_en) begin
      sc_rd_q <= scratch_mem[rd_idx_q];
    end
  end

  assign rd_word = d1_scr_q ? sc_rd_q : pt_rd_q;

  // a blend pairs the previous entry with the one just read
  assign lerp_en = d1_valid_q && !d1_emit_q && (d1_idx_q != '0);

  always_ff @(posedge clk_i) begin
    if (d1_valid_q) begin
      prev_q <= rd_word;
    end
    if (d1_valid_q && d1_emit_q) begin
      out_word_q <= rd_word;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bdc_lerp #(
      .COORD_BITS (COORD_BITS)
    ) u_lerp (
      .clk_i (clk_i),
      .en_i  (lerp_en),
      .a_i   (prev_q[g]),
      .b_i   (rd_word[g]),
      .t_i   (t_q),
      .res_o (blend_res[g])
    );
  end

  assign busy_o        = (state_q != S_IDLE);
  assign point_valid_o = out_valid_q;
  assign point_x_o     = OUT_W'($signed(out_word_q[0]));
  assign point_y_o     = OUT_W'($signed(out_word_q[1]));
  assign point_z_o     = OUT_W'($signed(out_word_q[2]));
  assign point_index_o = INDEX_W'(out_idx_q);
  assign last_point_o  = out_last_q;

  // a pass never reads the scratch entry that is being written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && rd_en) |-> (rd_idx_q != s1_addr_q))
    else $error("scratch read collides with write back");

  // the store never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  // the blend pipeline is empty whenever a new word may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !s1_valid_q)
    else $error("blend in flight while idle");

  // the final point of an evaluation is followed by a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_valid_o && last_point_o) |=> !point_valid_o)
    else $error("result right after the final point");

endmodule : bezier_de_casteljau_eval

`default_nettype wire
